@@ rtl/core/sbm_pkg.sv @@
// shared types, codes and constants of the sound cpu bank mapper
package sbm_pkg;

    localparam int RAM_DEPTH = 2048;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);
    localparam logic [RAM_AW-1:0] RAM_LAST = RAM_AW'(RAM_DEPTH - 1);

    localparam int ROM_AW  = 18;
    localparam int BANK0_W = 4;
    localparam int BANK1_W = 5;
    localparam int BANK2_W = 6;
    localparam int BANK3_W = 7;

    localparam logic [BANK0_W-1:0] BANK0_RESET = BANK0_W'(2);
    localparam logic [BANK1_W-1:0] BANK1_RESET = BANK1_W'(6);
    localparam logic [BANK2_W-1:0] BANK2_RESET = BANK2_W'(14);
    localparam logic [BANK3_W-1:0] BANK3_RESET = BANK3_W'(30);

    // bus function codes
    localparam logic [1:0] FUNC_MEM_READ  = 2'd0;
    localparam logic [1:0] FUNC_MEM_WRITE = 2'd1;
    localparam logic [1:0] FUNC_PORT_READ = 2'd2;
    localparam logic [1:0] FUNC_PORT_WRITE = 2'd3;

    // low byte of port reads
    localparam logic [7:0] PORT_CHIP0      = 8'h00;
    localparam logic [7:0] PORT_CHIP4      = 8'h04;
    localparam logic [7:0] PORT_CHIP5      = 8'h05;
    localparam logic [7:0] PORT_CHIP6      = 8'h06;
    localparam logic [7:0] PORT_BANK3_LOAD = 8'h08;
    localparam logic [7:0] PORT_BANK2_LOAD = 8'h09;
    localparam logic [7:0] PORT_BANK1_LOAD = 8'h0A;
    localparam logic [7:0] PORT_BANK0_LOAD = 8'h0B;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] address;
        logic [7:0]  write_data;
    } req_item_t;

    typedef struct packed {
        logic [7:0]        read_data;
        logic              rom_request;
        logic              rom_select;
        logic [ROM_AW-1:0] rom_address;
        logic              chip_request;
        logic              chip_is_write;
        logic [15:0]       chip_port;
        logic [7:0]        chip_data;
    } rsp_item_t;

endpackage

@@ rtl/core/sbm_req_if.sv @@
// bus access item channel
interface sbm_req_if;
    logic              valid;
    logic              ready;
    sbm_pkg::req_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/sbm_rsp_if.sv @@
// result item channel
interface sbm_rsp_if;
    logic              valid;
    logic              ready;
    sbm_pkg::rsp_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/sbm_cfg_if.sv @@
// configuration write channel
interface sbm_cfg_if;
    logic valid;
    logic ready;
    logic boot_rom_mapped;

    modport source (output valid, output boot_rom_mapped, input ready);
    modport sink (input valid, input boot_rom_mapped, output ready);
endinterface

@@ rtl/core/sound_cpu_bank_mapper_unit.sv @@
// top level of the sound cpu bank mapper: bank windows, local ram, port forwarding
//
//  channel  dir  payload
//  req      in   func, address, write_data
//  rsp      out  read_data, rom_*, chip_*
//  cfg      in   boot_rom_mapped
//
// one item per cycle while rsp is ready and the clearing pass is done; a taken item passes
// the ram read register, then the output register, before its result appears
// after reset the local ram is zeroed one entry a cycle, all 2048 entries, req.ready low
// cfg is always ready, also during the clearing pass
// a stalled rsp holds the pipeline; req.ready drops only while clearing or when both stages are full and rsp is stalled
module sound_cpu_bank_mapper_unit (
    input  logic      clk,
    input  logic      rst_n,
    sbm_req_if.sink   req,
    sbm_rsp_if.source rsp,
    sbm_cfg_if.sink   cfg
);

    logic [7:0] local_ram [sbm_pkg::RAM_DEPTH];

    logic                        boot_rom_mapped_reg;
    logic [sbm_pkg::BANK0_W-1:0] window0_bank_reg;
    logic [sbm_pkg::BANK1_W-1:0] window1_bank_reg;
    logic [sbm_pkg::BANK2_W-1:0] window2_bank_reg;
    logic [sbm_pkg::BANK3_W-1:0] window3_bank_reg;

    logic                       clear_done_reg;
    logic [sbm_pkg::RAM_AW-1:0] clear_addr_reg;

    logic                s1_valid_reg;
    logic                s1_ram_rd_reg;
    sbm_pkg::rsp_item_t  s1_data_reg;
    logic [7:0]          ram_rd_reg;
    logic                out_valid_reg;
    sbm_pkg::rsp_item_t  out_data_reg;

    logic                s1_adv;
    logic                accept;
    logic [7:0]          lo;
    logic [7:0]          hi;
    logic                in_ram;
    logic                ram_rd0;
    sbm_pkg::rsp_item_t  res0;
    sbm_pkg::rsp_item_t  out_next;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = clear_done_reg && (!s1_valid_reg || s1_adv);
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    assign lo     = req.data.address[7:0];
    assign hi     = req.data.address[15:8];
    assign in_ram = req.data.address[15:11] == 5'b11111;

    // result fields known at accept; ram byte joins from the ram read register when stage 1 advances
    always_comb
    begin
        res0    = '0;
        ram_rd0 = 1'b0;
        unique case (req.data.func)
            sbm_pkg::FUNC_MEM_READ:
            begin
                if (!req.data.address[15])
                begin
                    res0.rom_request = 1'b1;
                    res0.rom_select  = boot_rom_mapped_reg;
                    res0.rom_address = {2'b00, req.data.address};
                end
                else if (!req.data.address[14])
                begin
                    res0.rom_request = 1'b1;
                    res0.rom_address = {window0_bank_reg, req.data.address[13:0]};
                end
                else if (!req.data.address[13])
                begin
                    res0.rom_request = 1'b1;
                    res0.rom_address = {window1_bank_reg, req.data.address[12:0]};
                end
                else if (!req.data.address[12])
                begin
                    res0.rom_request = 1'b1;
                    res0.rom_address = {window2_bank_reg, req.data.address[11:0]};
                end
                else if (!in_ram)
                begin
                    res0.rom_request = 1'b1;
                    res0.rom_address = {window3_bank_reg, req.data.address[10:0]};
                end
                else
                begin
                    ram_rd0 = 1'b1;
                end
            end
            sbm_pkg::FUNC_MEM_WRITE:
            begin
                res0 = '0;
            end
            sbm_pkg::FUNC_PORT_READ:
            begin
                case (lo) inside
                    sbm_pkg::PORT_CHIP0, sbm_pkg::PORT_CHIP4,
                    sbm_pkg::PORT_CHIP5, sbm_pkg::PORT_CHIP6:
                    begin
                        res0.chip_request = 1'b1;
                        res0.chip_port    = req.data.address;
                    end
                    default:
                    begin
                        res0 = '0;
                    end
                endcase
            end
            sbm_pkg::FUNC_PORT_WRITE:
            begin
                res0.chip_request  = 1'b1;
                res0.chip_is_write = 1'b1;
                res0.chip_port     = req.data.address;
                res0.chip_data     = req.data.write_data;
            end
            default:
            begin
                res0 = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boot_rom_mapped_reg <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            boot_rom_mapped_reg <= cfg.boot_rom_mapped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window0_bank_reg <= sbm_pkg::BANK0_RESET;
            window1_bank_reg <= sbm_pkg::BANK1_RESET;
            window2_bank_reg <= sbm_pkg::BANK2_RESET;
            window3_bank_reg <= sbm_pkg::BANK3_RESET;
        end
        else if (accept && req.data.func == sbm_pkg::FUNC_PORT_READ)
        begin
            case (lo)
                sbm_pkg::PORT_BANK3_LOAD: window3_bank_reg <= hi[sbm_pkg::BANK3_W-1:0];
                sbm_pkg::PORT_BANK2_LOAD: window2_bank_reg <= hi[sbm_pkg::BANK2_W-1:0];
                sbm_pkg::PORT_BANK1_LOAD: window1_bank_reg <= hi[sbm_pkg::BANK1_W-1:0];
                sbm_pkg::PORT_BANK0_LOAD: window0_bank_reg <= hi[sbm_pkg::BANK0_W-1:0];
                default:
                begin
                    window0_bank_reg <= window0_bank_reg;
                end
            endcase
        end
    end

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_done_reg <= 1'b0;
            clear_addr_reg <= '0;
        end
        else if (!clear_done_reg)
        begin
            if (clear_addr_reg == sbm_pkg::RAM_LAST)
            begin
                clear_done_reg <= 1'b1;
            end
            else
            begin
                clear_addr_reg <= clear_addr_reg + 1'b1;
            end
        end
    end

    // ram write port: clearing pass or memory write into the top 2 KB
    always_ff @(posedge clk)
    begin
        if (!clear_done_reg)
        begin
            local_ram[clear_addr_reg] <= 8'h00;
        end
        else if (accept && req.data.func == sbm_pkg::FUNC_MEM_WRITE && in_ram)
        begin
            local_ram[req.data.address[sbm_pkg::RAM_AW-1:0]] <= req.data.write_data;
        end
    end

    // ram read port, holds while stage 1 is stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ram_rd_reg <= local_ram[req.data.address[sbm_pkg::RAM_AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_data_reg   <= res0;
            s1_ram_rd_reg <= ram_rd0;
        end
    end

    always_comb
    begin
        out_next           = s1_data_reg;
        out_next.read_data = s1_ram_rd_reg ? ram_rd_reg : 8'h00;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_data_reg <= out_next;
        end
    end

    // a result never asks for both rom and chip
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.rom_request && out_data_reg.chip_request))
        else $error("rom and chip request together");

    // a ram byte only comes with no external request
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.read_data != 8'h00)
        |-> (!out_data_reg.rom_request && !out_data_reg.chip_request))
        else $error("ram byte with external request");

    // a bank 0 load lands in the register at the next edge
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.data.func == sbm_pkg::FUNC_PORT_READ
            && lo == sbm_pkg::PORT_BANK0_LOAD)
        |=> window0_bank_reg == $past(hi[sbm_pkg::BANK0_W-1:0]))
        else $error("window0 bank load lost");

    // a stalled stage 1 takes no new item, so its ram byte is kept
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |-> !accept)
        else $error("item taken over stalled stage");

    // clearing finishes once per reset
    assert property (@(posedge clk) disable iff (!rst_n)
        clear_done_reg |=> clear_done_reg)
        else $error("clearing pass restarted");

endmodule
